/* hdl/cfc_pkg.sv */
// Shared constants, error codes and the CRC byte update for the command frame checker.
package cfc_pkg;

    localparam int FRAME_BYTES    = 128;
    localparam int RESERVED_START = 104;
    localparam int POS_W          = $clog2(FRAME_BYTES);

    localparam logic [7:0]       SYNC_VALUE    = 8'hA5;
    localparam logic [7:0]       VERSION_VALUE = 8'h04;
    localparam logic [7:0]       FLAGS_MASK    = 8'hFE;
    localparam logic [15:0]      CRC_POLY      = 16'h1021;
    localparam logic [15:0]      CRC_INIT      = 16'hFFFF;
    localparam logic [POS_W-1:0] CRC_BODY_END  = POS_W'(126);
    localparam logic [POS_W-1:0] LAST_POS      = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] RSV_START_POS = POS_W'(RESERVED_START);

    // Reported error codes, highest priority first after none
    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_SYNC     = 3'd1,
        ERR_TYPE     = 3'd2,
        ERR_VERSION  = 3'd3,
        ERR_FLAGS    = 3'd4,
        ERR_CRC      = 3'd5,
        ERR_RESERVED = 3'd6
    } err_code_t;

    // Bit positions in the sticky error flag vector
    localparam int FLG_SYNC     = 0;
    localparam int FLG_TYPE     = 1;
    localparam int FLG_VERSION  = 2;
    localparam int FLG_FLAGS    = 3;
    localparam int FLG_CRC      = 4;
    localparam int FLG_RESERVED = 5;
    localparam int FLG_W        = 6;

    // CRC-16/CCITT, MSB first, one byte per call
    function automatic logic [15:0] crc_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* hdl/command_frame_checker.sv */
// Top level of the command frame checker: byte stream in, annotated bytes and frame verdict out.
//
// Checks fixed 128-byte command frames arriving one byte per word on the input stream.
// A word with tuser set opens a new frame and drops any partial one; words outside a
// frame with tuser clear are consumed and produce nothing. Every frame byte comes out
// registered, with its index; the last byte carries tlast and the verdict (sync, type,
// version, flags, CRC, reserved, in that priority). The block takes one byte per cycle
// unless the output register holds a word the sink does not take: the eight-bit CRC step
// and the field checks sit between the input handshake and the output register, and the
// input keeps flowing while the output register holds a word as long as the sink takes it.
// command_type may be written at any time the stream is quiet; cfg_ready is always high.
module command_frame_checker
    import cfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write: expected type byte
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    // output byte stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_out, [14:8] byte_index, [15] frame_ok,
                                        // [18:16] error_code, [23:19] zero
    output logic        m_axis_tlast    // last_byte
);

    logic [7:0]        cmd_type_q_reg;
    logic              in_frame_reg,  in_frame_next;
    logic [POS_W-1:0]  pos_reg,       pos_next;
    logic [15:0]       crc_reg,       crc_next;
    logic [FLG_W-1:0]  flags_reg,     flags_next;
    logic [7:0]        crc_low_reg;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg;
    logic [POS_W-1:0]  out_idx_reg;
    logic              out_last_reg;
    logic              out_ok_reg;
    err_code_t         out_err_reg;

    logic              in_accept;
    logic              active;
    logic              is_last;
    logic [7:0]        b;
    logic [POS_W-1:0]  pos;
    logic [15:0]       crc_base;
    logic [FLG_W-1:0]  flags_base;
    err_code_t         code;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;

    // Hold the configured type byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_type_q_reg <= 8'h00;
        else if (cfg_valid && cfg_ready)
            cmd_type_q_reg <= cfg_data;
    end

    // Check the byte against the frame layout and advance the CRC
    always_comb
    begin
        active     = s_axis_tuser || in_frame_reg;
        pos        = s_axis_tuser ? '0 : pos_reg;
        crc_base   = s_axis_tuser ? CRC_INIT : crc_reg;
        flags_base = s_axis_tuser ? '0 : flags_reg;
        is_last    = (pos == LAST_POS);

        flags_next = flags_base;
        if (pos == POS_W'(0) && b != SYNC_VALUE)
            flags_next[FLG_SYNC] = 1'b1;
        if (pos == POS_W'(1) && b != cmd_type_q_reg)
            flags_next[FLG_TYPE] = 1'b1;
        if (pos == POS_W'(4) && (b & FLAGS_MASK) != 8'h00)
            flags_next[FLG_FLAGS] = 1'b1;
        if (pos == POS_W'(5) && b != VERSION_VALUE)
            flags_next[FLG_VERSION] = 1'b1;
        if (pos >= RSV_START_POS && pos < CRC_BODY_END && b != 8'h00)
            flags_next[FLG_RESERVED] = 1'b1;
        if (is_last && {b, crc_low_reg} != crc_base)
            flags_next[FLG_CRC] = 1'b1;

        crc_next = (pos < CRC_BODY_END) ? crc_update(crc_base, b) : crc_base;

        in_frame_next = !is_last;
        pos_next      = is_last ? '0 : pos + POS_W'(1);
    end

    // Pick the highest priority error of the finished frame
    always_comb
    begin
        priority if (!is_last)                code = ERR_NONE;
        else if (flags_next[FLG_SYNC])        code = ERR_SYNC;
        else if (flags_next[FLG_TYPE])        code = ERR_TYPE;
        else if (flags_next[FLG_VERSION])     code = ERR_VERSION;
        else if (flags_next[FLG_FLAGS])       code = ERR_FLAGS;
        else if (flags_next[FLG_CRC])         code = ERR_CRC;
        else if (flags_next[FLG_RESERVED])    code = ERR_RESERVED;
        else                                  code = ERR_NONE;
    end

    // Update frame state on each taken frame byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            crc_reg      <= CRC_INIT;
            flags_reg    <= '0;
        end
        else if (in_accept && active)
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            flags_reg    <= flags_next;
        end
    end

    // Capture the low CRC byte
    always_ff @(posedge clk)
    begin
        if (in_accept && active && pos == CRC_BODY_END)
            crc_low_reg <= b;
    end

    // Output word valid: set on a frame byte, drop when the sink takes it
    always_comb
    begin
        if (in_accept && active)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Load the output payload
    always_ff @(posedge clk)
    begin
        if (in_accept && active)
        begin
            out_data_reg <= b;
            out_idx_reg  <= pos;
            out_last_reg <= is_last;
            out_ok_reg   <= is_last && (code == ERR_NONE);
            out_err_reg  <= code;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {5'b0, out_err_reg, out_ok_reg, out_idx_reg, out_data_reg};

`ifndef SYNTHESIS
    // Verdict is consistent with the error code on the closing byte
    a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tdata[15] == (m_axis_tdata[18:16] == ERR_NONE)))
        else $error("frame_ok disagrees with error_code");

    // No verdict on bytes other than the last
    a_no_verdict_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |->
            (!m_axis_tdata[15] && m_axis_tdata[18:16] == ERR_NONE))
        else $error("verdict on a non-final byte");

    // Taking the final byte closes the frame
    a_frame_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && active && is_last) |=> (!in_frame_reg && pos_reg == '0))
        else $error("frame not closed after last byte");

    // Last flag tracks the byte index
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[14:8] == LAST_POS)))
        else $error("tlast does not match byte index");
`endif

endmodule
